### rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants for the fixed block pool allocator: default sizes,
// block geometry, word field widths and result status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbpa_pkg;

  // Default pool geometry handed to the top level parameters.
  localparam int BLOCK_COUNT_DEF = 32;
  localparam int PID_BITS_DEF    = 8;

  // Block size in bytes; a power of two so that address decode is a shift.
  localparam int BLOCK_BYTES = 128;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  // Field widths of the stream words.
  localparam int ADDR_W     = 32;
  localparam int PID_IN_W   = 8;
  localparam int STATUS_W   = 3;
  localparam int GIDX_W     = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // Operation codes carried in the input tuser.
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NONE_USED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE_FREE = 3'd4;

endpackage

### rtl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Each item is read from the owner and free-list memories, then modified and
// written back together with the output register; no new input word is accepted
// until the write-back, and a stalled output holds the item in flight.
// Reset: a clearing pass over all BLOCK_COUNT entries loads the free list and
// marks every block free; no input word is accepted until it completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_block_pool_allocator #(
  parameter int BLOCK_COUNT = fbpa_pkg::BLOCK_COUNT_DEF,
  parameter int PID_BITS    = fbpa_pkg::PID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: pool_base
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::ADDR_W-1:0]     cfg_wdata,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [7:0] process_id, [39:8] block_address
  input  logic [fbpa_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] opcode
  input  logic                            s_tuser,
  // Output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [2:0] status, [34:3] granted_address, [39:35] granted_index
  output logic [fbpa_pkg::OUT_DATA_W-1:0] m_tdata
);

  import fbpa_pkg::*;

  localparam int IDX_W     = $clog2(BLOCK_COUNT);
  localparam int CNT_W     = $clog2(BLOCK_COUNT + 1);
  localparam int OWN_W     = PID_BITS + 1;
  localparam int BLK_NUM_W = ADDR_W - BLOCK_SHIFT;
  localparam int PID_KEEP  = (PID_BITS < PID_IN_W) ? PID_BITS : PID_IN_W;

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BLOCK_COUNT - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(BLOCK_COUNT);

  // Control registers
  logic [1:0]          state;
  logic [IDX_W-1:0]    init_cnt;
  logic [ADDR_W-1:0]   pool_base;
  logic [IDX_W-1:0]    free_head;
  logic [IDX_W-1:0]    free_tail;
  logic [CNT_W-1:0]    free_count;
  logic [CNT_W-1:0]    used_count;

  // Item held between the read and write-back cycles
  logic                op_q;
  logic [PID_BITS-1:0] pid_q;
  logic [IDX_W-1:0]    rel_idx_q;
  logic                rel_bad_q;

  // Memories and their registered read data
  logic [IDX_W-1:0]    fifo_mem  [BLOCK_COUNT];
  logic [OWN_W-1:0]    owner_mem [BLOCK_COUNT];
  logic [IDX_W-1:0]    fifo_rd;
  logic [OWN_W-1:0]    owner_rd;

  // Output register fields
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_addr;
  logic [GIDX_W-1:0]   out_idx;

  // Combinational signals
  logic                accept;
  logic                exec_go;
  logic [ADDR_W-1:0]   in_addr;
  logic [ADDR_W-1:0]   offset;
  logic [BLK_NUM_W-1:0] blk_num;
  logic                rel_bad;
  logic [IDX_W-1:0]    rel_idx;
  logic [PID_BITS-1:0] pid_in;

  logic                fifo_we;
  logic [IDX_W-1:0]    fifo_waddr;
  logic [IDX_W-1:0]    fifo_wdata;
  logic                owner_we;
  logic [IDX_W-1:0]    owner_waddr;
  logic [OWN_W-1:0]    owner_wdata;

  logic                take_head;
  logic                push_tail;
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;
  logic [IDX_W-1:0]    res_idx;
  logic [ADDR_W-1:0]   res_idx_wide;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign exec_go  = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign m_tdata  = {out_idx, out_addr, out_status};

  // Release address decode: offset from the pool base, split into block number
  // and byte offset within the block.
  assign in_addr = s_tdata[IN_DATA_W-1:PID_IN_W];
  assign offset  = in_addr - pool_base;
  assign blk_num = offset[ADDR_W-1:BLOCK_SHIFT];
  assign rel_bad = (offset[BLOCK_SHIFT-1:0] != '0) ||
                   (blk_num >= BLK_NUM_W'(BLOCK_COUNT));
  assign rel_idx = blk_num[IDX_W-1:0];
  assign pid_in  = PID_BITS'(s_tdata[PID_KEEP-1:0]);

  // Decide the result and the memory updates of the item in flight.
  always_comb begin
    take_head  = 1'b0;
    push_tail  = 1'b0;
    res_status = ST_OK;
    res_addr   = '0;
    res_idx    = '0;
    if (op_q == OP_REQUEST) begin
      if (free_count == '0) begin
        res_status = ST_NONE_FREE;
      end else begin
        take_head = 1'b1;
        res_idx   = fifo_rd;
        res_addr  = pool_base + (ADDR_W'(fifo_rd) << BLOCK_SHIFT);
      end
    end else begin
      if (used_count == '0) begin
        res_status = ST_NONE_USED;
      end else if (rel_bad_q) begin
        res_status = ST_BAD_ADDR;
      end else if (!owner_rd[PID_BITS] || (owner_rd[PID_BITS-1:0] != pid_q)) begin
        res_status = ST_NOT_OWNER;
      end else begin
        push_tail = 1'b1;
        res_idx   = rel_idx_q;
      end
    end
  end

  assign res_idx_wide = ADDR_W'(res_idx);

  // Memory write ports: the clearing pass, or the write-back of one item.
  always_comb begin
    fifo_we     = 1'b0;
    fifo_waddr  = free_tail;
    fifo_wdata  = rel_idx_q;
    owner_we    = 1'b0;
    owner_waddr = rel_idx_q;
    owner_wdata = '0;
    if (state == S_INIT) begin
      fifo_we     = 1'b1;
      fifo_waddr  = init_cnt;
      fifo_wdata  = init_cnt;
      owner_we    = 1'b1;
      owner_waddr = init_cnt;
    end else if (exec_go) begin
      if (take_head) begin
        owner_we    = 1'b1;
        owner_waddr = fifo_rd;
        owner_wdata = {1'b1, pid_q};
      end else if (push_tail) begin
        fifo_we  = 1'b1;
        owner_we = 1'b1;
      end
    end
  end

  // Free list memory
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
    if (accept) begin
      fifo_rd <= fifo_mem[free_head];
    end
  end

  // Owner table memory: in-use flag above the owning process
  always_ff @(posedge clk) begin
    if (owner_we) begin
      owner_mem[owner_waddr] <= owner_wdata;
    end
    if (accept) begin
      owner_rd <= owner_mem[rel_idx];
    end
  end

  // Item registers, loaded when a word is accepted
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= s_tuser;
      pid_q     <= pid_in;
      rel_idx_q <= rel_idx;
      rel_bad_q <= rel_bad;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status <= res_status;
      out_addr   <= res_addr;
      out_idx    <= res_idx_wide[GIDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (cfg_we) begin
      pool_base <= cfg_wdata;
    end
  end

  // Sequencer, pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_cnt   <= '0;
      free_head  <= '0;
      free_tail  <= '0;
      free_count <= FULL_CNT;
      used_count <= '0;
    end else begin
      case (state)
        S_INIT: begin
          if (init_cnt == LAST_IDX) begin
            state <= S_IDLE;
          end else begin
            init_cnt <= init_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state <= S_IDLE;
            if (take_head) begin
              free_head  <= (free_head == LAST_IDX) ? '0 : free_head + 1'b1;
              free_count <= free_count - 1'b1;
              used_count <= used_count + 1'b1;
            end else if (push_tail) begin
              free_tail  <= (free_tail == LAST_IDX) ? '0 : free_tail + 1'b1;
              free_count <= free_count + 1'b1;
              used_count <= used_count - 1'b1;
            end
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Every block is either free or in use.
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    (CNT_W + 1)'(free_count) + (CNT_W + 1)'(used_count) == (CNT_W + 1)'(BLOCK_COUNT))
    else $error("free and used counts do not cover the pool");

  // An accepted word always moves to the write-back cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted word did not enter write-back");

  // A result appears only from the write-back cycle.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_EXEC))
    else $error("result word without a write-back");

  // A failed item never reports an address.
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_status != ST_OK)) |-> (out_addr == '0))
    else $error("failed item carries a granted address");
`endif

endmodule
